// File: rtl/mks_pkg.sv
// types, constants and register indexes shared by the keypad scanner modules
package mks_pkg;

    localparam int ROWS = 4;
    localparam int COLS = 4;

    localparam int ROW_W   = 2;
    localparam int COL_W   = 2;
    localparam int LINE_W  = 4;
    localparam int CODE_W  = 8;
    localparam int MAP_W   = 64;
    localparam int COUNT_W = 16;

    localparam logic [LINE_W-1:0] COL_MASK = LINE_W'((1 << COLS) - 1);

    localparam logic [CODE_W-1:0]  NO_KEY_RESET   = 8'd255;
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd20;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_MAP_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_MAP_HIGH   = 2'd1;
    localparam logic [1:0] REG_NO_KEY_CODE    = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd3;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [COUNT_W-1:0]   count;
    } t_state;

    typedef struct packed {
        logic [MAP_W-1:0]     key_map_high;
        logic [MAP_W-1:0]     key_map_low;
        logic [CODE_W-1:0]    no_key_code;
        logic [COUNT_W-1:0]   debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic [LINE_W-1:0]    row_drive;
        logic                 key_valid;
        logic                 scan_empty;
        logic [CODE_W-1:0]    key_code;
    } t_result;

endpackage

// File: rtl/matrix_keypad_scanner.sv
// top level of the 4x4 keypad scanner: stream ports, configuration and state registers
// Each accepted tick request carries the column levels sampled for the row driven
// so far and yields exactly one result through the output register: the row levels to drive
// next, a released-key flag or an empty-scan flag, and the key code. A new tick is
// taken every clock; the only limit is the single output register, which takes a
// new result whenever it is empty or its result is taken in the same cycle.
// Configuration writes are taken at once and should only be issued while idle.
module matrix_keypad_scanner
    import mks_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [3:0] column_levels
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [3:0] row_drive, [11:4] key_code
    output logic [1:0]           m_axis_tuser,   // [0] key_valid, [1] scan_empty
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [MAP_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_result;
    logic    r_out_valid;
    logic    in_accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    mks_step u_step (
        .i_state         (r_state),
        .i_cfg           (r_cfg),
        .i_column_levels (s_axis_tdata[LINE_W-1:0]),
        .o_next_state    (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_map_low    <= '0;
            r_cfg.key_map_high   <= '0;
            r_cfg.no_key_code    <= NO_KEY_RESET;
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_MAP_LOW:    r_cfg.key_map_low    <= i_cfg_data;
                REG_KEY_MAP_HIGH:   r_cfg.key_map_high   <= i_cfg_data;
                REG_NO_KEY_CODE:    r_cfg.no_key_code    <= i_cfg_data[CODE_W-1:0];
                REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_SCAN;
            r_state.row   <= '0;
            r_state.col   <= '0;
            r_state.count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.key_code, r_out.row_drive};
    assign m_axis_tuser  = {r_out.scan_empty, r_out.key_valid};

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key_valid && r_out.scan_empty))
        else $error("key_valid and scan_empty both set");

    a_release_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_result.key_valid) |=>
            (r_state.phase == PH_RELEASED) && (r_out.row_drive == '1))
        else $error("rows not released after key release");

    a_debounce_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DEBOUNCE) |-> (r_state.count != '0))
        else $error("debouncing with zero count");

    a_released_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_RELEASED) |-> (r_state.row == '0) && (r_state.col == '0))
        else $error("released phase away from row 0 column 0");
`endif

endmodule

// File: rtl/mks_step.sv
// one scan tick: next scan state and the result for one column sample
module mks_step
    import mks_pkg::*;
(
    input  t_state             i_state,
    input  t_cfg               i_cfg,
    input  logic [LINE_W-1:0]  i_column_levels,
    output t_state             o_next_state,
    output t_result            o_result
);

    logic [LINE_W-1:0]  pressed;
    logic [LINE_W-1:0]  cand;
    logic [ROW_W-1:0]   row_eff;
    logic [COL_W-1:0]   col_eff;
    logic [COL_W-1:0]   first_col;
    logic               col_down;
    logic               last_row;
    logic               last_col;
    logic               confirm_tick;
    logic [3:0]         map_idx;
    logic [2*MAP_W-1:0] key_map;

    always_comb begin
        pressed  = ~i_column_levels & COL_MASK;
        row_eff  = (int'(i_state.row) >= ROWS) ? '0 : i_state.row;
        col_eff  = (int'(i_state.col) >= COLS) ? '0 : i_state.col;
        cand     = pressed & (LINE_W'(4'hF << col_eff));
        col_down = pressed[col_eff];
        last_row = (int'(row_eff) + 1) >= ROWS;
        last_col = (int'(col_eff) + 1) >= COLS;
        // count at one or zero means this sample is the confirming one
        confirm_tick = (i_state.count <= COUNT_W'(1));
        first_col = '0;
        for (int c = LINE_W - 1; c >= 0; c--) begin
            if (cand[c]) begin
                first_col = COL_W'(c);
            end
        end
    end

    // next state
    always_comb begin
        o_next_state     = i_state;
        o_next_state.row = row_eff;
        o_next_state.col = col_eff;
        case (i_state.phase)
            PH_SCAN: begin
                if (cand != '0) begin
                    o_next_state.col = first_col;
                    if (i_cfg.debounce_ticks == '0) begin
                        o_next_state.phase = PH_HOLD;
                    end else begin
                        o_next_state.count = i_cfg.debounce_ticks;
                        o_next_state.phase = PH_DEBOUNCE;
                    end
                end else begin
                    o_next_state.col = '0;
                    o_next_state.row = last_row ? '0 : row_eff + ROW_W'(1);
                end
            end
            PH_DEBOUNCE: begin
                if (!confirm_tick) begin
                    o_next_state.count = i_state.count - COUNT_W'(1);
                end else begin
                    o_next_state.count = '0;
                    if (col_down) begin
                        o_next_state.phase = PH_HOLD;
                    end else begin
                        o_next_state.phase = PH_SCAN;
                        if (last_col) begin
                            o_next_state.col = '0;
                            o_next_state.row = last_row ? '0 : row_eff + ROW_W'(1);
                        end else begin
                            o_next_state.col = col_eff + COL_W'(1);
                        end
                    end
                end
            end
            PH_HOLD: begin
                if (!col_down) begin
                    o_next_state.row   = '0;
                    o_next_state.col   = '0;
                    o_next_state.phase = PH_RELEASED;
                end
            end
            default: begin
                o_next_state.row   = '0;
                o_next_state.col   = '0;
                o_next_state.phase = PH_SCAN;
            end
        endcase
    end

    // result
    always_comb begin
        key_map  = {i_cfg.key_map_high, i_cfg.key_map_low};
        map_idx  = {row_eff, col_eff};
        o_result = '0;
        case (i_state.phase)
            PH_SCAN: begin
                o_result.scan_empty = (cand == '0) && last_row;
            end
            PH_DEBOUNCE: begin
                o_result.scan_empty = confirm_tick && !col_down && last_col && last_row;
            end
            PH_HOLD: begin
                o_result.key_valid = !col_down;
            end
            default: begin
                o_result.key_valid = 1'b0;
            end
        endcase
        if (o_result.scan_empty) begin
            o_result.key_code = i_cfg.no_key_code;
        end else if (o_result.key_valid) begin
            o_result.key_code = key_map[map_idx*CODE_W +: CODE_W];
        end
        if (o_next_state.phase == PH_RELEASED) begin
            o_result.row_drive = '1;
        end else begin
            o_result.row_drive = ~(LINE_W'(1) << o_next_state.row);
        end
    end

endmodule

// File: sim/tb.sv
// self-checking testbench for the keypad scanner: directed steps, then random keypad traffic
`timescale 1ns / 1ps

module tb;
    import mks_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 6;
    localparam int PHASE_TICKS  = 125;
    localparam int DRAIN_CYCLES = 4;

    // one directed step: a register write or a tick, optionally with a typed report
    typedef struct packed {
        logic              is_write;
        logic [1:0]        reg_idx;
        logic [MAP_W-1:0]  reg_val;
        logic [LINE_W-1:0] levels;
        logic              typed;
        t_result           report;
    } t_step;

    localparam t_step OPENING_STEPS [28] = '{
        '{1'b0, '0, '0, 4'hF, 1'b1, '{4'b1101, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'hF, 1'b1, '{4'b1011, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'hF, 1'b1, '{4'b0111, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'hF, 1'b1, '{4'b1110, 1'b0, 1'b1, NO_KEY_RESET}},
        '{1'b1, REG_KEY_MAP_LOW, 64'hF7E6_D5C4_B3A2_9180, 4'h0, 1'b0, '0},
        '{1'b1, REG_KEY_MAP_HIGH, 64'h7F6E_5D4C_3B2A_1908, 4'h0, 1'b0, '0},
        '{1'b1, REG_NO_KEY_CODE, 64'h00, 4'h0, 1'b0, '0},
        '{1'b1, REG_DEBOUNCE_TICKS, 64'd0, 4'h0, 1'b0, '0},
        // zero settle time: press on column 3 is held at once, release emits its code
        '{1'b0, '0, '0, 4'b0111, 1'b1, '{4'b1110, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'b0111, 1'b1, '{4'b1110, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'hF, 1'b1, '{4'b1111, 1'b1, 1'b0, 8'hB3}},
        '{1'b0, '0, '0, 4'h0, 1'b1, '{4'b1110, 1'b0, 1'b0, 8'h00}},
        '{1'b0, '0, '0, 4'h0, 1'b0, '0},
        '{1'b0, '0, '0, 4'hE, 1'b0, '0},
        '{1'b0, '0, '0, 4'h1, 1'b0, '0},
        '{1'b0, '0, '0, 4'hF, 1'b0, '0},
        '{1'b1, REG_DEBOUNCE_TICKS, 64'd1, 4'h0, 1'b0, '0},
        // confirm fails, scan resumes past the dropped column
        '{1'b0, '0, '0, 4'b1101, 1'b0, '0},
        '{1'b0, '0, '0, 4'hF, 1'b0, '0},
        '{1'b0, '0, '0, 4'b1110, 1'b0, '0},
        '{1'b1, REG_DEBOUNCE_TICKS, 64'd2, 4'h0, 1'b0, '0},
        // failed confirm on the last column of row 1, then of row 3
        '{1'b0, '0, '0, 4'b0111, 1'b0, '0},
        '{1'b0, '0, '0, 4'b0111, 1'b0, '0},
        '{1'b0, '0, '0, 4'hF, 1'b0, '0},
        '{1'b0, '0, '0, 4'hF, 1'b0, '0},
        '{1'b0, '0, '0, 4'b0111, 1'b0, '0},
        '{1'b0, '0, '0, 4'b0111, 1'b0, '0},
        '{1'b0, '0, '0, 4'hF, 1'b0, '0}
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index   = '0;
    logic [MAP_W-1:0]  i_cfg_data    = '0;

    // scanner model: settings and state
    logic [MAP_W-1:0]   map_lo       = '0;
    logic [MAP_W-1:0]   map_hi       = '0;
    logic [CODE_W-1:0]  empty_code   = NO_KEY_RESET;
    logic [COUNT_W-1:0] settle_ticks = DEBOUNCE_RESET;
    t_phase             ph           = PH_SCAN;
    logic [ROW_W-1:0]   row          = '0;
    logic [COL_W-1:0]   col          = '0;
    logic [COUNT_W-1:0] settle_left  = '0;

    t_result reports_due[$];
    int      errors         = 0;
    int      ticks_sent     = 0;
    int      idle_cycles    = 0;
    int      stall_requests = 0;
    int      stalls_served  = 0;
    bit      tx_quiet       = 1'b0;

    matrix_keypad_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // move to column 0 of the next row, returns 1 when the scan wrapped
    function automatic bit step_row();
        col = '0;
        if (row == ROW_W'(ROWS - 1)) begin
            row = '0;
            return 1'b1;
        end
        row = row + 1'b1;
        return 1'b0;
    endfunction

    function automatic t_result scan_tick(input logic [LINE_W-1:0] levels);
        t_result           rep;
        logic [LINE_W-1:0] down;
        logic [LINE_W-1:0] cand;
        logic [3:0]        key;
        logic              held;
        bit                empty;
        rep   = '0;
        empty = 1'b0;
        down  = ~levels & COL_MASK;
        held  = down[col];
        case (ph)
            PH_SCAN: begin
                cand = down & (4'hF << col);
                if (cand != '0) begin
                    for (int i = LINE_W - 1; i >= 0; i--)
                        if (cand[i]) col = COL_W'(i);
                    if (settle_ticks == '0) begin
                        ph = PH_HOLD;
                    end else begin
                        settle_left = settle_ticks;
                        ph = PH_DEBOUNCE;
                    end
                end else begin
                    empty = step_row();
                end
            end
            PH_DEBOUNCE: begin
                if (settle_left > 1) begin
                    settle_left = settle_left - 1'b1;
                end else begin
                    settle_left = '0;
                    if (held) begin
                        ph = PH_HOLD;
                    end else begin
                        ph = PH_SCAN;
                        if (col == COL_W'(COLS - 1)) empty = step_row();
                        else col = col + 1'b1;
                    end
                end
            end
            PH_HOLD: begin
                if (!held) begin
                    key = {row, col};
                    rep.key_valid = 1'b1;
                    rep.key_code  = key[3] ? map_hi[key[2:0]*8 +: 8] : map_lo[key[2:0]*8 +: 8];
                    row = '0;
                    col = '0;
                    ph  = PH_RELEASED;
                end
            end
            default: begin
                row = '0;
                col = '0;
                ph  = PH_SCAN;
            end
        endcase
        if (empty) begin
            rep.scan_empty = 1'b1;
            rep.key_code   = empty_code;
        end
        rep.row_drive = (ph == PH_RELEASED) ? 4'hF : ~(LINE_W'(1) << row);
        return rep;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_tick(input logic [LINE_W-1:0] levels, input logic typed,
                             input t_result typed_rep);
        int      gap;
        t_result rep;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, levels};
        do @(posedge i_clk); while (!s_axis_tready);
        rep = scan_tick(levels);
        reports_due.push_back(typed ? typed_rep : rep);
        ticks_sent++;
    endtask

    // keypad with the given keys down: columns follow the row being driven
    task automatic press_keys(input logic [15:0] keys, input int ticks, input bit bouncy);
        logic [LINE_W-1:0] lv;
        repeat (ticks) begin
            lv = (ph == PH_RELEASED) ? 4'hF : ~keys[row*4 +: 4];
            if (bouncy && $urandom_range(0, 19) == 0) lv = lv ^ 4'($urandom_range(1, 15));
            send_tick(lv, 1'b0, '0);
        end
    endtask

    // settings change only once every report is out
    task automatic write_reg(input logic [1:0] idx, input logic [MAP_W-1:0] val);
        if (s_axis_tvalid) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        while (reports_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_KEY_MAP_LOW:    map_lo       = val;
            REG_KEY_MAP_HIGH:   map_hi       = val;
            REG_NO_KEY_CODE:    empty_code   = val[CODE_W-1:0];
            REG_DEBOUNCE_TICKS: settle_ticks = val[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // report sink with random back-pressure and one long hold-off on request
    initial begin
        int rx_wait;
        bit rx_quiet;
        rx_wait  = 0;
        rx_quiet = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stalls_served != stall_requests) begin
                stalls_served++;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
            end
            if ($urandom_range(0, 127) == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                got.row_drive  = m_axis_tdata[3:0];
                got.key_valid  = m_axis_tuser[0];
                got.scan_empty = m_axis_tuser[1];
                got.key_code   = m_axis_tdata[11:4];
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected report, drive %h valid %b empty %b code %h",
                             $time, got.row_drive, got.key_valid, got.scan_empty, got.key_code);
                    errors++;
                end else begin
                    want = reports_due.pop_front();
                    if (got.row_drive !== want.row_drive) begin
                        $display("%0t: row_drive expected %h got %h",
                                 $time, want.row_drive, got.row_drive);
                        errors++;
                    end
                    if (got.key_valid !== want.key_valid) begin
                        $display("%0t: key_valid expected %b got %b",
                                 $time, want.key_valid, got.key_valid);
                        errors++;
                    end
                    if (got.scan_empty !== want.scan_empty) begin
                        $display("%0t: scan_empty expected %b got %b",
                                 $time, want.scan_empty, got.scan_empty);
                        errors++;
                    end
                    if (got.key_code !== want.key_code) begin
                        $display("%0t: key_code expected %h got %h",
                                 $time, want.key_code, got.key_code);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        logic [MAP_W-1:0]   lo_val;
        logic [MAP_W-1:0]   hi_val;
        logic [CODE_W-1:0]  nk_val;
        logic [COUNT_W-1:0] db_val;
        logic [15:0]        keys;
        int                 start;
        int                 kind;
        int                 d;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING_STEPS[i]) begin
            if (OPENING_STEPS[i].is_write)
                write_reg(OPENING_STEPS[i].reg_idx, OPENING_STEPS[i].reg_val);
            else
                send_tick(OPENING_STEPS[i].levels, OPENING_STEPS[i].typed,
                          OPENING_STEPS[i].report);
        end

        // long settle time: row 1 column 2 held through the whole count
        tx_quiet = 1'b1;
        write_reg(REG_DEBOUNCE_TICKS, 64'd100);
        press_keys(16'h0040, 110, 1'b0);
        press_keys(16'h0000, 3, 1'b0);
        tx_quiet = 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            lo_val = {$urandom, $urandom};
            hi_val = {$urandom, $urandom};
            nk_val = 8'($urandom);
            db_val = 16'($urandom_range(0, 8));
            case (p)
                0: db_val = '0;
                1: begin
                    lo_val = '1;
                    hi_val = '1;
                    nk_val = '1;
                    db_val = 16'd1;
                end
                2: begin
                    nk_val = '0;
                    db_val = 16'd3;
                end
                4: begin
                    lo_val = '0;
                    hi_val = '0;
                    db_val = 16'd2;
                end
                5: db_val = 16'($urandom_range(4, 12));
                default: ;
            endcase
            write_reg(REG_KEY_MAP_LOW, lo_val);
            write_reg(REG_KEY_MAP_HIGH, hi_val);
            write_reg(REG_NO_KEY_CODE, MAP_W'(nk_val));
            write_reg(REG_DEBOUNCE_TICKS, MAP_W'(db_val));
            if (p == 2) stall_requests++;
            d = int'(settle_ticks);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                if ($urandom_range(0, 7) == 0) tx_quiet = ($urandom_range(0, 2) == 0);
                kind = $urandom_range(0, 9);
                keys = 16'(1) << $urandom_range(0, 15);
                if (kind <= 5) begin
                    press_keys(keys, d + $urandom_range(3, 12), 1'b1);
                end else if (kind == 6) begin
                    keys = keys | (16'(1) << $urandom_range(0, 15));
                    press_keys(keys, d + $urandom_range(3, 12), 1'b1);
                end else if (kind == 7) begin
                    // too short to confirm, most of the time
                    press_keys(keys, $urandom_range(1, d + 2), 1'b1);
                end else begin
                    repeat ($urandom_range(1, 8)) send_tick(4'($urandom_range(0, 15)), 1'b0, '0);
                end
                if (kind <= 7) press_keys(16'h0000, $urandom_range(1, 4), 1'b1);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
